### src/ica_pkg.sv
`default_nettype none

package ica_pkg;

  // Input transaction: one raw IMU sample
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [15:0] elapsed_ms;
  } imu_sample_t;

  // Output transaction: blended attitude, degrees Q15.16
  typedef struct packed {
    logic signed [31:0] pitch_deg;
    logic signed [31:0] roll_deg;
    logic signed [31:0] yaw_step_deg;
  } attitude_t;

  // Configuration register indexes
  localparam logic [2:0] REG_GYRO_FULL_SCALE = 3'd0;
  localparam logic [2:0] REG_GYRO_OFFSET_X   = 3'd1;
  localparam logic [2:0] REG_GYRO_OFFSET_Y   = 3'd2;
  localparam logic [2:0] REG_GYRO_OFFSET_Z   = 3'd3;
  localparam logic [2:0] REG_ACCEL_WEIGHT    = 3'd4;

  localparam logic [1:0]  GYRO_FULL_SCALE_RST = 2'd3;
  localparam logic [15:0] ACCEL_WEIGHT_RST    = 16'd3277;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // 90 degrees in Q16
  localparam logic signed [26:0] DEG90_Q16 = 27'sd5898240;

  // CORDIC arctangent table, degrees Q16
  function automatic logic [21:0] atan_entry(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/imu_complementary_attitude.sv
// IMU complementary attitude estimator.
// Input channel (in_valid / in_stall / in_data): one raw IMU sample per
// transaction; a transaction completes on a clock edge with in_valid high and
// in_stall low. Output channel (out_valid / out_stall / out_data): one result
// per sample with blended pitch, roll and this step's yaw angle, Q15.16 deg.
// Configuration: cfg_write with cfg_index / cfg_data writes one register
// (full scale, three gyro offsets, accelerometer weight); write only when idle.
// A new sample is taken once the result is in the output register; the block
// does not take a new sample while it is still working on the last one. The
// pace is set by the shared CORDIC stage, run twice per sample one
// micro-rotation per cycle, and by the single 22x17 multiplier, used seven
// times per sample.
// Reset (rst, synchronous) restores the register defaults, clears both
// angles and empties the output register.
// If the receiver stalls, the result holds in the output register and the
// block still takes and works on the next sample; it then waits before the
// result stage until the held result has been taken.
`default_nettype none

module imu_complementary_attitude
  import ica_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire imu_sample_t in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      attitude_t   out_data,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NSTEP     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CNT_W     = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int STEP_W    = 36;   // gyro step width
  localparam int CW        = 28;   // CORDIC x/y width
  localparam int ZW        = 27;   // CORDIC angle width

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_GMUL   = 10'b0000000010,
    S_GACC   = 10'b0000000100,
    S_CINIT  = 10'b0000001000,
    S_CITER  = 10'b0000010000,
    S_BSUB   = 10'b0000100000,
    S_BMUL_L = 10'b0001000000,
    S_BMUL_H = 10'b0010000000,
    S_BFIN   = 10'b0100000000,
    S_PUSH   = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic        [1:0]  fs;
  logic signed [15:0] off_x, off_y, off_z;
  logic        [15:0] weight;

  // Attitude state
  logic signed [31:0] roll_angle, pitch_angle;

  // Working registers
  imu_sample_t              sample;
  logic        [1:0]        gidx;
  logic                     axis;      // 0 roll, 1 pitch
  logic        [CNT_W-1:0]  cnt;
  logic signed [STEP_W-1:0] step_x, step_y, step_z;
  logic signed [CW-1:0]     cx, cy;
  logic signed [ZW-1:0]     cz;
  logic                     czero;
  logic signed [ZW-1:0]     tilt_roll, tilt_pitch;
  logic signed [36:0]       g_q;
  logic signed [37:0]       e_q;
  logic        [16:0]       lo_q;

  // Shared multiplier
  logic signed [21:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [38:0] mul_p;

  // Combinational datapath
  logic signed [16:0]       d_x, d_y, d_z, d_sel;
  logic signed [38:0]       gp;
  logic signed [STEP_W-1:0] step_new;
  logic signed [16:0]       abs_ax, abs_ay;
  logic signed [17:0]       v_x, v_y;
  logic signed [CW-1:0]     xs, ys;
  logic signed [CW-1:0]     cx_next, cy_next, sh_x, sh_y;
  logic signed [ZW-1:0]     cz_next, at_val, tilt_new;
  logic signed [31:0]       angle_sel;
  logic signed [STEP_W-1:0] step_sel;
  logic signed [ZW-1:0]     tilt_sel;
  logic signed [36:0]       g_new;
  logic signed [37:0]       e_new;
  logic        [32:0]       lo_sum;
  logic signed [39:0]       blend_sum;
  logic signed [31:0]       blend_sat;
  logic signed [31:0]       yaw_sat;
  logic                     push_ok;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign push_ok  = !out_valid || !out_stall;

  // Gyro: rate less offset, product scaled by full scale, halved rounding up
  always_comb begin
    d_x = 17'(sample.rate_x) - 17'(off_x);
    d_y = 17'(sample.rate_y) - 17'(off_y);
    d_z = 17'(sample.rate_z) - 17'(off_z);
    unique case (gidx)
      2'd0:    d_sel = d_x;
      2'd1:    d_sel = d_y;
      default: d_sel = d_z;
    endcase
    gp       = (mul_p <<< fs) + 39'sd1;
    step_new = STEP_W'(gp >>> 1);
    yaw_sat  = sat32(40'(step_z));
  end

  // CORDIC: start vector with pre-rotation, and one micro-rotation
  always_comb begin
    abs_ax = 17'(sample.accel_x);
    abs_ax = abs_ax[16] ? -abs_ax : abs_ax;
    abs_ay = 17'(sample.accel_y);
    abs_ay = abs_ay[16] ? -abs_ay : abs_ay;
    if (axis) begin
      v_y = 18'(sample.accel_x);
      v_x = 18'(sample.accel_z) + 18'(abs_ay);
    end else begin
      v_y = 18'(sample.accel_y);
      v_x = 18'(sample.accel_z) + 18'(abs_ax);
    end
    xs = CW'(v_x) <<< 8;
    ys = CW'(v_y) <<< 8;

    sh_x   = cx >>> cnt;
    sh_y   = cy >>> cnt;
    at_val = ZW'(atan_entry(5'(cnt)));
    if (!cy[CW-1]) begin
      cx_next = cx + sh_y;
      cy_next = cy - sh_x;
      cz_next = cz + at_val;
    end else begin
      cx_next = cx - sh_y;
      cy_next = cy + sh_x;
      cz_next = cz - at_val;
    end
    if (czero) begin
      tilt_new = '0;
    end else if (axis) begin
      tilt_new = -cz_next;
    end else begin
      tilt_new = cz_next;
    end
  end

  // Blend: angle = g + (tilt - g) * w / 2^16, rounded half up
  always_comb begin
    angle_sel = axis ? pitch_angle : roll_angle;
    step_sel  = axis ? step_y : step_x;
    tilt_sel  = axis ? tilt_pitch : tilt_roll;
    g_new     = 37'(angle_sel) + 37'(step_sel);
    e_new     = 38'(tilt_sel) - 38'(g_new);
    lo_sum    = {1'b0, mul_p[31:0]} + 33'd32768;
    blend_sum = 40'(g_q) + 40'(mul_p) + 40'($signed({1'b0, lo_q}));
    blend_sat = sat32(blend_sum);
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_GMUL: begin
        mul_a = 22'(d_sel);
        mul_b = $signed({1'b0, sample.elapsed_ms});
      end
      S_BMUL_L: begin
        mul_a = $signed({6'd0, e_q[15:0]});
        mul_b = $signed({1'b0, weight});
      end
      S_BMUL_H: begin
        mul_a = e_q[37:16];
        mul_b = $signed({1'b0, weight});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= 39'(mul_a * mul_b);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fs     <= GYRO_FULL_SCALE_RST;
      off_x  <= '0;
      off_y  <= '0;
      off_z  <= '0;
      weight <= ACCEL_WEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GYRO_FULL_SCALE: fs     <= cfg_data[1:0];
        REG_GYRO_OFFSET_X:   off_x  <= cfg_data;
        REG_GYRO_OFFSET_Y:   off_y  <= cfg_data;
        REG_GYRO_OFFSET_Z:   off_z  <= cfg_data;
        REG_ACCEL_WEIGHT:    weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      roll_angle  <= '0;
      pitch_angle <= '0;
      gidx        <= '0;
      axis        <= 1'b0;
      cnt         <= '0;
    end else begin
      // Result register: load on push, clear once taken
      if (state == S_PUSH && push_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            gidx  <= '0;
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          state <= S_GACC;
        end
        S_GACC: begin
          if (gidx == 2'd2) begin
            axis  <= 1'b0;
            state <= S_CINIT;
          end else begin
            gidx  <= gidx + 2'd1;
            state <= S_GMUL;
          end
        end
        S_CINIT: begin
          cnt   <= '0;
          state <= S_CITER;
        end
        S_CITER: begin
          if (cnt == CNT_W'(NSTEP - 1)) begin
            axis  <= !axis;
            state <= axis ? S_BSUB : S_CINIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BSUB: begin
          state <= S_BMUL_L;
        end
        S_BMUL_L: begin
          state <= S_BMUL_H;
        end
        S_BMUL_H: begin
          state <= S_BFIN;
        end
        S_BFIN: begin
          if (axis) begin
            pitch_angle <= blend_sat;
            state       <= S_PUSH;
          end else begin
            roll_angle <= blend_sat;
            axis       <= 1'b1;
            state      <= S_BSUB;
          end
        end
        S_PUSH: begin
          if (push_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          sample <= in_data;
        end
      end
      S_GACC: begin
        unique case (gidx)
          2'd0:    step_x <= step_new;
          2'd1:    step_y <= step_new;
          default: step_z <= step_new;
        endcase
      end
      S_CINIT: begin
        czero <= (v_x == 18'sd0) && (v_y == 18'sd0);
        if (xs[CW-1]) begin
          if (!ys[CW-1]) begin
            cx <= ys;
            cy <= -xs;
            cz <= DEG90_Q16;
          end else begin
            cx <= -ys;
            cy <= xs;
            cz <= -DEG90_Q16;
          end
        end else begin
          cx <= xs;
          cy <= ys;
          cz <= '0;
        end
      end
      S_CITER: begin
        cx <= cx_next;
        cy <= cy_next;
        cz <= cz_next;
        if (cnt == CNT_W'(NSTEP - 1)) begin
          if (axis) begin
            tilt_pitch <= tilt_new;
          end else begin
            tilt_roll <= tilt_new;
          end
        end
      end
      S_BSUB: begin
        g_q <= g_new;
        e_q <= e_new;
      end
      S_BMUL_H: begin
        lo_q <= lo_sum[32:16];
      end
      S_PUSH: begin
        if (push_ok) begin
          out_data.pitch_deg    <= pitch_angle;
          out_data.roll_deg     <= roll_angle;
          out_data.yaw_step_deg <= yaw_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/ica_checker.sv
`default_nettype none

module ica_checker
  import ica_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire imu_sample_t in_data,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire attitude_t   out_data,
  input wire logic        cfg_write,
  input wire logic [2:0]  cfg_index,
  input wire logic [15:0] cfg_data
);

  // Reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // An accepted sample keeps the block busy (in_stall high) afterwards
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall)
    else $error("ready too soon after input transaction");

  // A new result is only loaded while the block is busy with a sample
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // A stalled result stays and does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind imu_complementary_attitude ica_checker u_ica_checker (.*);

`default_nettype wire
